>>> hdl/utfc_pkg.sv
`timescale 1ns / 1ps

package utfc_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned COUNT_W = 17;

	localparam logic [COUNT_W-1:0] COUNT_CAP = 17'h10000;
	localparam logic [LEN_W-1:0]   MAX_LENGTH_RESET = 16'd4096;

	// second-byte limit set by the lead byte
	typedef enum logic [2:0] {
		LIM_NONE = 3'd0,
		LIM_E0   = 3'd1,
		LIM_ED   = 3'd2,
		LIM_F0   = 3'd3,
		LIM_F4   = 3'd4
	} limit_t;

	typedef struct packed {
		logic [1:0]         bytes_pending;
		limit_t             next_byte_limit;
		logic [COUNT_W-1:0] seen_count;
		logic               error_seen;
	} text_state_t;

endpackage

>>> hdl/utfc_decode.sv
`timescale 1ns / 1ps

module utfc_decode import utfc_pkg::*; (
	input  logic [BYTE_W-1:0] text_byte,
	input  text_state_t       cur,
	output text_state_t       nxt
);

	logic cont_ok;

	always_comb begin
		nxt = cur;
		cont_ok = (text_byte[7:6] == 2'b10);

		// saturating byte count
		if (cur.seen_count < COUNT_CAP) begin
			nxt.seen_count = cur.seen_count + COUNT_W'(1);
		end

		// control bytes
		if (text_byte < 8'h20 || text_byte == 8'h7f) begin
			nxt.error_seen = 1'b1;
		end

		if (cur.bytes_pending != 2'd0) begin
			case (cur.next_byte_limit)
				LIM_E0:  if (text_byte < 8'ha0) cont_ok = 1'b0;
				LIM_ED:  if (text_byte >= 8'ha0) cont_ok = 1'b0;
				LIM_F0:  if (text_byte < 8'h90) cont_ok = 1'b0;
				LIM_F4:  if (text_byte >= 8'h90) cont_ok = 1'b0;
				default: ;
			endcase
			nxt.next_byte_limit = LIM_NONE;
			if (cont_ok) begin
				nxt.bytes_pending = cur.bytes_pending - 2'd1;
			end else begin
				nxt.error_seen    = 1'b1;
				nxt.bytes_pending = 2'd0;
			end
		end else begin
			if (text_byte inside {[8'h00:8'h7f]}) begin
				// single byte
			end else if (text_byte inside {[8'hc2:8'hdf]}) begin
				nxt.bytes_pending = 2'd1;
			end else if (text_byte inside {[8'he0:8'hef]}) begin
				nxt.bytes_pending = 2'd2;
				if (text_byte == 8'he0) nxt.next_byte_limit = LIM_E0;
				else if (text_byte == 8'hed) nxt.next_byte_limit = LIM_ED;
			end else if (text_byte inside {[8'hf0:8'hf4]}) begin
				nxt.bytes_pending = 2'd3;
				if (text_byte == 8'hf0) nxt.next_byte_limit = LIM_F0;
				else if (text_byte == 8'hf4) nxt.next_byte_limit = LIM_F4;
			end else begin
				nxt.error_seen = 1'b1;
			end
		end
	end

endmodule

>>> hdl/utf8_safe_text_checker_core.sv
`timescale 1ns / 1ps
// strict utf-8 text checker, one byte per transaction
// result path: a last byte is taken into the input register, and its result is then written to the output register
// throughput: one byte per cycle, sustained while the result side keeps up
// a last byte waits in the input register only while an older result is untaken
// reset: arst_n clears the text state, both valid flags and sets max_length to 4096

module utf8_safe_text_checker_core import utfc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [LEN_W-1:0]   cfg_wdata,
	// byte input
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [BYTE_W-1:0]  text_byte,
	input  logic               last_byte,
	// result output
	output logic               out_valid,
	input  logic               out_ready,
	output logic               text_valid,
	output logic [COUNT_W-1:0] byte_count
);

	// configuration register
	logic [LEN_W-1:0] max_length_q;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// running decode state of the current text
	text_state_t state_q;
	text_state_t state_nxt;

	// result register
	logic               out_valid_q;
	logic               text_valid_q;
	logic [COUNT_W-1:0] byte_count_q;

	logic out_free;
	logic advance;
	logic result_ok;

	// the result slot is free when empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;
	// a middle byte always moves on; a last byte needs the result slot
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || advance;

	utfc_decode u_decode (
		.text_byte (byte_s1),
		.cur       (state_q),
		.nxt       (state_nxt)
	);

	// bounded length, no fault, no sequence cut short
	assign result_ok = !state_nxt.error_seen && (state_nxt.bytes_pending == 2'd0)
		&& (state_nxt.seen_count <= {1'b0, max_length_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RESET;
		end else if (cfg_we) begin
			max_length_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
			last_s1 <= last_byte;
		end
	end

	// text state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{bytes_pending: 2'd0, next_byte_limit: LIM_NONE,
				seen_count: '0, error_seen: 1'b0};
		end else if (advance) begin
			if (last_s1) begin
				state_q <= '{bytes_pending: 2'd0, next_byte_limit: LIM_NONE,
					seen_count: '0, error_seen: 1'b0};
			end else begin
				state_q <= state_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			text_valid_q <= result_ok;
			byte_count_q <= state_nxt.seen_count;
		end
	end

	assign out_valid  = out_valid_q;
	assign text_valid = text_valid_q;
	assign byte_count = byte_count_q;

endmodule
